>>> rtl/mpeq_pkg.sv
// shared types and codes for the multi-level priority event queue
package mpeq_pkg;

  localparam logic CMD_POST = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic        command;
    logic [2:0]  priority_req;
    logic [31:0] event_handle;
    logic [63:0] event_payload;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  taken_priority;
    logic [31:0] taken_handle;
    logic [63:0] taken_payload;
  } rsp_item_t;

  // what the ring control decided for the current request
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] status;
    logic [2:0] level;
  } decision_t;

endpackage

>>> rtl/mpeq_ring_ctrl.sv
// ring pointers, full/empty checks and level select for the event queue
module mpeq_ring_ctrl #(
  parameter int LEVEL_COUNT = 4,
  parameter int RING_LENGTH = 16,
  parameter int HANDLE_BITS = 32,
  parameter int ADDR_W      = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mpeq_pkg::req_item_t req,
  output mpeq_pkg::decision_t dec,
  output logic [ADDR_W-1:0]   waddr,
  output logic [ADDR_W-1:0]   raddr
);
  import mpeq_pkg::*;

  localparam int PTR_W = $clog2(RING_LENGTH);
  localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  logic [PTR_W-1:0] rd_ptr [LEVEL_COUNT];
  logic [PTR_W-1:0] wr_ptr [LEVEL_COUNT];

  logic [LEVEL_COUNT-1:0] full;
  logic [LEVEL_COUNT-1:0] nonempty;

  logic             level_ok;
  logic             post_ok;
  logic [LVL_W-1:0] post_lvl;
  logic [LVL_W-1:0] take_lvl;
  logic             found;
  logic [PTR_W-1:0] post_ptr;
  logic [PTR_W-1:0] take_ptr;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    ring_next = (pos == PTR_W'(RING_LENGTH - 1)) ? '0 : pos + PTR_W'(1);
  endfunction

  always_comb begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      full[l]     = (ring_next(wr_ptr[l]) == rd_ptr[l]);
      nonempty[l] = (rd_ptr[l] != wr_ptr[l]);
    end
  end

  // lowest-numbered non-empty level wins
  always_comb begin
    found    = 1'b0;
    take_lvl = '0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (!found && nonempty[l]) begin
        found    = 1'b1;
        take_lvl = LVL_W'(l);
      end
    end
  end

  assign level_ok = (int'(req.priority_req) < LEVEL_COUNT);
  assign post_lvl = req.priority_req[LVL_W-1:0];
  // zero check on the handle as it is stored
  assign post_ok  = level_ok && (HANDLE_BITS'(req.event_handle) != '0);
  assign post_ptr = wr_ptr[post_lvl];
  assign take_ptr = rd_ptr[take_lvl];

  assign waddr = ADDR_W'(int'(post_lvl) * RING_LENGTH + int'(post_ptr));
  assign raddr = ADDR_W'(int'(take_lvl) * RING_LENGTH + int'(take_ptr));

  always_comb begin
    dec = '0;
    if (req.command == CMD_TAKE) begin
      if (found) begin
        dec.rd_en  = 1'b1;
        dec.status = ST_OK;
        dec.level  = 3'(take_lvl);
      end else begin
        dec.status = ST_EMPTY;
      end
    end else begin
      if (!post_ok) begin
        dec.status = ST_INVALID;
      end else if (full[post_lvl]) begin
        dec.status = ST_FULL;
      end else begin
        dec.wr_en  = 1'b1;
        dec.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        rd_ptr[l] <= '0;
        wr_ptr[l] <= '0;
      end
    end else if (accept) begin
      if (dec.wr_en) begin
        wr_ptr[post_lvl] <= ring_next(post_ptr);
      end
      if (dec.rd_en) begin
        rd_ptr[take_lvl] <= ring_next(take_ptr);
      end
    end
  end

endmodule

>>> rtl/multi_priority_event_queue_unit.sv
// top level of the multi-level priority event queue
// the result of an accepted request is shown in the cycle after its acceptance
// throughput: one request per cycle unless the result stalls; the pointer
//   update and level encoder finish in the accept cycle, store read registered
// reset clears all ring pointers and the result valid; the event store
//   itself is not cleared and holds data only once written
module multi_priority_event_queue_unit #(
  parameter int LEVEL_COUNT  = 4,
  parameter int RING_LENGTH  = 16,
  parameter int HANDLE_BITS  = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mpeq_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mpeq_pkg::rsp_item_t rsp
);
  import mpeq_pkg::*;

  localparam int DEPTH  = LEVEL_COUNT * RING_LENGTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [HANDLE_BITS-1:0]  handle_store  [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_store [DEPTH];

  logic                    accept;
  decision_t               dec;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;

  logic                    rsp_valid_next;
  logic [1:0]              status;
  logic [2:0]              level;
  logic                    took;
  logic [HANDLE_BITS-1:0]  handle_q;
  logic [PAYLOAD_BITS-1:0] payload_q;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  mpeq_ring_ctrl #(
    .LEVEL_COUNT (LEVEL_COUNT),
    .RING_LENGTH (RING_LENGTH),
    .HANDLE_BITS (HANDLE_BITS),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .dec    (dec),
    .waddr  (waddr),
    .raddr  (raddr)
  );

  // event store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && dec.wr_en) begin
      handle_store[waddr]  <= HANDLE_BITS'(req.event_handle);
      payload_store[waddr] <= PAYLOAD_BITS'(req.event_payload);
    end
    if (accept && dec.rd_en) begin
      handle_q  <= handle_store[raddr];
      payload_q <= payload_store[raddr];
    end
  end

  always_comb begin
    if (accept) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= dec.status;
      level  <= dec.level;
      took   <= dec.rd_en;
    end
  end

  // results other than a successful take show zero in the taken fields
  assign rsp.status         = status;
  assign rsp.taken_priority = took ? level : 3'd0;
  assign rsp.taken_handle   = took ? 32'(handle_q) : 32'd0;
  assign rsp.taken_payload  = took ? 64'(payload_q) : 64'd0;

endmodule

>>> bench/multi_priority_event_queue_unit_tb.sv
// self-checking testbench for the multi-level priority event queue unit
`timescale 1ns / 1ps

module multi_priority_event_queue_unit_tb;
  import mpeq_pkg::*;

  localparam int LEVELS    = 4;
  localparam int RING      = 16;
  localparam int LONG_HOLD = 200;

  // tracks ring contents per level and the results they imply
  class priority_queue_tracker;
    logic [31:0] handle_mem [LEVELS][RING];
    logic [63:0] payload_mem [LEVELS][RING];
    int unsigned rd_pos [LEVELS];
    int unsigned wr_pos [LEVELS];
    rsp_item_t   pending_results [$];
    int unsigned mismatch_count;

    function new();
      foreach (rd_pos[i]) begin
        rd_pos[i] = 0;
        wr_pos[i] = 0;
      end
      mismatch_count = 0;
    endfunction

    function void note_request(req_item_t r);
      rsp_item_t   want;
      int unsigned lvl;
      int unsigned nxt;
      want = '0;
      if (r.command == CMD_POST) begin
        lvl = r.priority_req;
        if (r.event_handle == '0 || lvl >= LEVELS) begin
          want.status = ST_INVALID;
        end else begin
          // one slot stays free so full and empty differ
          nxt = (wr_pos[lvl] + 1) % RING;
          if (nxt == rd_pos[lvl]) begin
            want.status = ST_FULL;
          end else begin
            handle_mem[lvl][wr_pos[lvl]]  = r.event_handle;
            payload_mem[lvl][wr_pos[lvl]] = r.event_payload;
            wr_pos[lvl] = nxt;
            want.status = ST_OK;
          end
        end
      end else begin
        want.status = ST_EMPTY;
        for (int i = 0; i < LEVELS; i++) begin
          if (rd_pos[i] != wr_pos[i]) begin
            want.status         = ST_OK;
            want.taken_priority = 3'(i);
            want.taken_handle   = handle_mem[i][rd_pos[i]];
            want.taken_payload  = payload_mem[i][rd_pos[i]];
            rd_pos[i] = (rd_pos[i] + 1) % RING;
            break;
          end
        end
      end
      pending_results.push_back(want);
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d handle %h", got.status, got.taken_handle);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatch_count++;
      end
      if (got.taken_priority !== want.taken_priority) begin
        $error("taken_priority: expected %0d, got %0d", want.taken_priority,
               got.taken_priority);
        mismatch_count++;
      end
      if (got.taken_handle !== want.taken_handle) begin
        $error("taken_handle: expected %h, got %h", want.taken_handle, got.taken_handle);
        mismatch_count++;
      end
      if (got.taken_payload !== want.taken_payload) begin
        $error("taken_payload: expected %h, got %h", want.taken_payload,
               got.taken_payload);
        mismatch_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  bit          hold_pending = 1'b0;

  priority_queue_tracker sb;

  multi_priority_event_queue_unit #(
    .LEVEL_COUNT (LEVELS),
    .RING_LENGTH (RING),
    .HANDLE_BITS (32),
    .PAYLOAD_BITS(64)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
    end
  end

  // result side: random stall, plus one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic req_item_t make_request(logic cmd, logic [2:0] prio,
                                             logic [31:0] handle, logic [63:0] payload);
    req_item_t r;
    r.command       = cmd;
    r.priority_req  = prio;
    r.event_handle  = handle;
    r.event_payload = payload;
    return r;
  endfunction

  // most posts go to one focus level so its ring fills up
  function automatic req_item_t random_request(int unsigned post_pct, int unsigned focus);
    req_item_t   r;
    int unsigned sel;
    r.command = ($urandom_range(99) < post_pct) ? CMD_POST : CMD_TAKE;
    sel = $urandom_range(99);
    if (sel < 65) r.priority_req = 3'(focus);
    else if (sel < 92) r.priority_req = 3'($urandom_range(LEVELS - 1));
    else r.priority_req = 3'($urandom_range(7, LEVELS));
    r.event_handle = $urandom;
    sel = $urandom_range(99);
    if (sel < 5) r.event_handle = '0;
    else if (sel < 8) r.event_handle = '1;
    else if (r.event_handle == '0) r.event_handle = 32'd1;
    r.event_payload = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 3) r.event_payload = '0;
    else if (sel < 6) r.event_payload = '1;
    return r;
  endfunction

  task automatic send_request(input req_item_t r);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
  endtask

  // one edge first so the last accepted request is already recorded
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_burst(int unsigned count, int unsigned post_pct);
    int unsigned focus;
    focus = $urandom_range(LEVELS - 1);
    repeat (count) send_request(random_request(post_pct, focus));
  endtask

  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, int unsigned bursts);
    int unsigned post_pct;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    // receiver holds off while posts keep coming, then the sender waits it out
    hold_pending = 1'b1;
    run_burst(40, 100);
    wait_drained();
    repeat (bursts) begin
      case ($urandom_range(3))
        0: post_pct = 90;
        1: post_pct = 55;
        2: post_pct = 20;
        default: post_pct = 70;
      endcase
      run_burst(40, post_pct);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, rejected posts, extremes, then drain in level order
    send_request(make_request(CMD_TAKE, 3'd7, '1, '1));
    send_request(make_request(CMD_POST, 3'd0, 32'd0, 64'h1234_5678_9abc_def0));
    send_request(make_request(CMD_POST, 3'd4, 32'd5, 64'd5));
    send_request(make_request(CMD_POST, 3'd7, '1, '1));
    send_request(make_request(CMD_POST, 3'd3, 32'd1, '0));
    send_request(make_request(CMD_POST, 3'd2, '1, '1));
    send_request(make_request(CMD_POST, 3'd1, 32'ha5a5_5a5a, 64'h0123_4567_89ab_cdef));
    send_request(make_request(CMD_POST, 3'd0, 32'h8000_0000, 64'h8000_0000_0000_0000));
    send_request(make_request(CMD_POST, 3'd0, 32'd2, 64'd1));
    send_request(make_request(CMD_TAKE, 3'd0, '0, '0));
    send_request(make_request(CMD_TAKE, 3'd5, 32'hdead_beef, '1));
    send_request(make_request(CMD_TAKE, 3'd3, '1, 64'h5555_aaaa_5555_aaaa));
    send_request(make_request(CMD_TAKE, 3'd1, 32'd0, '0));
    send_request(make_request(CMD_TAKE, 3'd6, '1, '1));
    send_request(make_request(CMD_TAKE, 3'd2, 32'd9, 64'd9));
    send_request(make_request(CMD_POST, 3'd3, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff));
    send_request(make_request(CMD_TAKE, 3'd0, '0, '0));
    wait_drained();

    run_phase(25, 72, 13);
    run_phase(72, 25, 13);
    run_phase(0, 0, 13);

    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> multi_priority_event_queue_unit.f
rtl/mpeq_pkg.sv
rtl/mpeq_ring_ctrl.sv
rtl/multi_priority_event_queue_unit.sv
bench/multi_priority_event_queue_unit_tb.sv
